// ----- src/bpt_pkg.sv -----
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants for the breakpoint table.
// ----------------------------------------------------------------------------
package bpt_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = 9;
	localparam int LINE_W   = 16;
	localparam int SERIAL_W = 16;
	localparam int POS_W    = 8;
	localparam int FUNC_W   = 3;

	localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_HAS    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	typedef struct packed {
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic                ok;
		logic [SERIAL_W-1:0] found_serial;
		logic [LINE_W-1:0]   found_line;
		logic [CNT_W-1:0]    occupancy;
	} result_t;

endpackage

// ----- src/breakpoint_table.sv -----
// ----------------------------------------------------------------------------
// breakpoint_table
// Insertion-ordered breakpoint table: add, remove, has, get and clear.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lsb first)                        | width
//  s_axis   | in  | func, line_number, serial, position             | 48
//  m_axis   | out | ok, found_serial, found_line, occupancy         | 48
//
// Every operation completes at the edge that accepts it: all entries are compared in
// parallel and removal shifts the entry cells down in the same edge.
// One transfer per cycle is sustained while m_tready is high; the result register frees as it is taken.
// Reset clears the entry count and the serial counter; no clearing pass.
// A stalled result blocks new input until m_tready is high.
// ----------------------------------------------------------------------------
module breakpoint_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // func[2:0], line_number[18:3], serial[34:19], position[42:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // ok[0], found_serial[16:1], found_line[32:17], occupancy[41:33]
);
	import bpt_pkg::*;

	dp_cmd_t cmd;
	result_t res;

	logic [FUNC_W-1:0]   func;
	logic [LINE_W-1:0]   line_number;
	logic [SERIAL_W-1:0] serial;
	logic [POS_W-1:0]    position;

	assign func        = s_tdata[2:0];
	assign line_number = s_tdata[18:3];
	assign serial      = s_tdata[34:19];
	assign position    = s_tdata[42:35];

	bpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	bpt_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.line_number (line_number),
		.serial      (serial),
		.position    (position),
		.res         (res)
	);

	assign m_tdata = {6'd0, res.occupancy, res.found_line, res.found_serial, res.ok};

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy beyond table depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && func == FN_CLEAR) |=>
		(m_tvalid && res.ok && res.occupancy == '0))
		else $error("clear did not empty the table");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted transfer produced no result");

endmodule

// ----- src/bpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpt_ctrl
// Handshake controller: issues the execute command and holds the result slot.
// ----------------------------------------------------------------------------
module bpt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output bpt_pkg::dp_cmd_t cmd
);
	import bpt_pkg::*;

	typedef enum logic {
		ST_EMPTY,
		ST_HOLD
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_EMPTY) || m_tready;
	assign cmd.exec = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			case (state_q)
				ST_EMPTY: begin
					if (cmd.exec)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (m_tready && !cmd.exec)
						state_q <= ST_EMPTY;
				end
				default: state_q <= ST_EMPTY;
			endcase
		end
	end

endmodule

// ----- src/bpt_datapath.sv -----
// ----------------------------------------------------------------------------
// bpt_datapath
// Entry cells with per-entry compares, shift-down removal and result register.
// ----------------------------------------------------------------------------
module bpt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bpt_pkg::dp_cmd_t                cmd,
	input  logic [bpt_pkg::FUNC_W-1:0]      func,
	input  logic [bpt_pkg::LINE_W-1:0]      line_number,
	input  logic [bpt_pkg::SERIAL_W-1:0]    serial,
	input  logic [bpt_pkg::POS_W-1:0]       position,
	output bpt_pkg::result_t                res
);
	import bpt_pkg::*;

	logic [LINE_W-1:0]   line_q   [DEPTH];
	logic [SERIAL_W-1:0] serial_q [DEPTH];
	logic [CNT_W-1:0]    used_q;
	logic [SERIAL_W-1:0] ctr_q;
	result_t             res_q;

	logic [DEPTH-1:0]    valid;
	logic [DEPTH-1:0]    line_hit;
	logic [DEPTH-1:0]    ser_hit;
	logic [DEPTH-1:0]    shift_en;
	logic                full;
	logic                add_ok;
	logic                rm_ok;
	logic                get_ok;
	logic [IDX_W-1:0]    wr_idx;
	logic [IDX_W-1:0]    get_idx;
	logic [SERIAL_W-1:0] ser_next;
	logic [CNT_W-1:0]    used_next;
	logic [SERIAL_W-1:0] ctr_next;
	result_t             res_d;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid[i]    = CNT_W'(i) < used_q;
			line_hit[i] = valid[i] && (line_q[i] == line_number);
			ser_hit[i]  = valid[i] && (serial_q[i] == serial);
		end
		// entries at and above the first serial match move down one place
		for (int i = 0; i < DEPTH; i++) begin
			shift_en[i] = 1'b0;
			for (int j = 0; j < DEPTH; j++) begin
				if (j <= i)
					shift_en[i] = shift_en[i] | ser_hit[j];
			end
		end
	end

	assign full     = (used_q == CNT_W'(DEPTH));
	assign add_ok   = !full && !(|line_hit);
	assign rm_ok    = |ser_hit;
	assign get_ok   = (CNT_W'(position) < used_q) && (CNT_W'(position) < CNT_W'(DEPTH));
	assign wr_idx   = used_q[IDX_W-1:0];
	assign get_idx  = position[IDX_W-1:0];
	assign ser_next = ctr_q + SERIAL_W'(1);

	always_comb begin
		used_next = used_q;
		ctr_next  = ctr_q;
		res_d     = '0;
		case (func)
			FN_ADD: begin
				if (add_ok) begin
					used_next          = used_q + CNT_W'(1);
					ctr_next           = ser_next;
					res_d.ok           = 1'b1;
					res_d.found_serial = ser_next;
				end
			end
			FN_REMOVE: begin
				if (rm_ok) begin
					used_next = used_q - CNT_W'(1);
					res_d.ok  = 1'b1;
				end
			end
			FN_HAS: res_d.ok = |line_hit;
			FN_GET: begin
				if (get_ok) begin
					res_d.ok           = 1'b1;
					res_d.found_serial = serial_q[get_idx];
					res_d.found_line   = line_q[get_idx];
				end
			end
			FN_CLEAR: begin
				used_next = '0;
				ctr_next  = '0;
				res_d.ok  = 1'b1;
			end
			default: ;
		endcase
		res_d.occupancy = used_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ctr_q  <= '0;
		end else if (cmd.exec) begin
			used_q <= used_next;
			ctr_q  <= ctr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
			if (func == FN_ADD && add_ok) begin
				line_q[wr_idx]   <= line_number;
				serial_q[wr_idx] <= ser_next;
			end
			if (func == FN_REMOVE) begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					if (shift_en[i]) begin
						line_q[i]   <= line_q[i+1];
						serial_q[i] <= serial_q[i+1];
					end
				end
			end
		end
	end

	assign res = res_q;

endmodule

// ----- verif/breakpoint_table_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_table_chk
// Watches both streams of the breakpoint table. It keeps its own copy of the
// table to predict each command's result, then compares every result transfer
// field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module breakpoint_table_chk
	import bpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,  // func[2:0], line_number[18:3], serial[34:19], position[42:35]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // ok[0], found_serial[16:1], found_line[32:17], occupancy[41:33]
	output int          errors,
	output int          outstanding,
	output int          checked
);

	logic [LINE_W-1:0]   bp_line   [DEPTH];
	logic [SERIAL_W-1:0] bp_serial [DEPTH];
	int                  bp_count;
	logic [SERIAL_W-1:0] last_serial;
	result_t             due_results [$];
	result_t             got;
	result_t             want;

	function automatic result_t run_command(input logic [FUNC_W-1:0]   fn,
	                                        input logic [LINE_W-1:0]   ln,
	                                        input logic [SERIAL_W-1:0] sn,
	                                        input logic [POS_W-1:0]    pos);
		result_t r;
		int      hit;
		r   = '0;
		hit = -1;
		case (fn)
		FN_ADD: begin
			for (int i = 0; i < bp_count; i++)
				if (bp_line[i] == ln)
					hit = i;
			if (bp_count < DEPTH && hit < 0) begin
				last_serial         = last_serial + 1'b1;
				bp_line[bp_count]   = ln;
				bp_serial[bp_count] = last_serial;
				bp_count++;
				r.ok           = 1'b1;
				r.found_serial = last_serial;
			end
		end
		FN_REMOVE: begin
			for (int i = 0; i < bp_count; i++)
				if (hit < 0 && bp_serial[i] == sn)
					hit = i;
			if (hit >= 0) begin
				for (int j = hit; j < bp_count - 1; j++) begin
					bp_line[j]   = bp_line[j + 1];
					bp_serial[j] = bp_serial[j + 1];
				end
				bp_count--;
				r.ok = 1'b1;
			end
		end
		FN_HAS: begin
			for (int i = 0; i < bp_count; i++)
				if (bp_line[i] == ln)
					r.ok = 1'b1;
		end
		FN_GET: begin
			if (int'(pos) < bp_count) begin
				r.ok           = 1'b1;
				r.found_serial = bp_serial[pos];
				r.found_line   = bp_line[pos];
			end
		end
		FN_CLEAR: begin
			bp_count    = 0;
			last_serial = '0;
			r.ok        = 1'b1;
		end
		default: begin
		end
		endcase
		r.occupancy = CNT_W'(bp_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_count    = 0;
			last_serial = '0;
			due_results.delete();
			errors      <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (s_tvalid && s_tready)
				due_results.push_back(run_command(s_tdata[2:0], s_tdata[18:3],
				                                  s_tdata[34:19], s_tdata[42:35]));
			if (m_tvalid && m_tready) begin
				got.ok           = m_tdata[0];
				got.found_serial = m_tdata[16:1];
				got.found_line   = m_tdata[32:17];
				got.occupancy    = m_tdata[41:33];
				checked <= checked + 1;
				if (due_results.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result ok %0d serial %0d line %0d occupancy %0d",
						         $realtime, got.ok, got.found_serial, got.found_line,
						         got.occupancy);
					errors <= errors + 1;
				end else begin
					want = due_results.pop_front();
					if (got.ok !== want.ok || got.found_serial !== want.found_serial ||
					    got.found_line !== want.found_line ||
					    got.occupancy !== want.occupancy) begin
						if (errors < 10)
							$display("%0t: mismatch, expected ok %0d serial %0d line %0d occ %0d, got ok %0d serial %0d line %0d occ %0d",
							         $realtime, want.ok, want.found_serial, want.found_line,
							         want.occupancy, got.ok, got.found_serial,
							         got.found_line, got.occupancy);
						errors <= errors + 1;
					end
				end
			end
			outstanding <= due_results.size();
		end
	end

endmodule

// ----- verif/breakpoint_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_table_tb
// Drives commands into the breakpoint table: a directed set of edge cases,
// then random command mixes under varying stalls on both streams. The checker
// alongside does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module breakpoint_table_tb;
	import bpt_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;  // func[2:0], line_number[18:3], serial[34:19], position[42:35]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // ok[0], found_serial[16:1], found_line[32:17], occupancy[41:33]

	int errors;
	int outstanding;
	int checked;
	int src_gap_pct  = 0;
	int sink_gap_pct = 0;
	int sent         = 0;
	int adds_since_clear = 0;

	always #6 clk = ~clk;

	breakpoint_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	breakpoint_table_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_gap_pct);
	end

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic issue_command(input logic [FUNC_W-1:0]   fn,
	                             input logic [LINE_W-1:0]   ln,
	                             input logic [SERIAL_W-1:0] sn,
	                             input logic [POS_W-1:0]    pos);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, pos, sn, ln, fn};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		sent++;
		if (fn == FN_ADD)
			adds_since_clear++;
		else if (fn == FN_CLEAR)
			adds_since_clear = 0;
	endtask

	task automatic random_phase(input int count);
		int                  pick;
		logic [FUNC_W-1:0]   fn;
		logic [LINE_W-1:0]   ln;
		logic [SERIAL_W-1:0] sn;
		logic [POS_W-1:0]    pos;
		for (int n = 0; n < count; n++) begin
			// occasional burst of adds to drive the table to full
			if ($urandom_range(59) == 0) begin
				for (int k = 0; k < 18; k++)
					issue_command(FN_ADD, LINE_W'($urandom_range(255)), '0, '0);
				n += 17;
				continue;
			end
			pick = $urandom_range(99);
			ln   = ($urandom_range(9) == 0) ? LINE_W'($urandom) : LINE_W'($urandom_range(23));
			sn   = ($urandom_range(9) == 0) ? SERIAL_W'($urandom)
			                                : SERIAL_W'($urandom_range(adds_since_clear + 1));
			pos  = ($urandom_range(7) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(DEPTH + 1));
			if (pick < 38)
				fn = FN_ADD;
			else if (pick < 58)
				fn = FN_REMOVE;
			else if (pick < 72)
				fn = FN_HAS;
			else if (pick < 92)
				fn = FN_GET;
			else if (pick < 95)
				fn = FN_CLEAR;
			else
				fn = FUNC_W'($urandom_range(7, 5));
			issue_command(fn, ln, sn, pos);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_command(FN_CLEAR,  16'd0,     16'd0, 8'd0);
		issue_command(FN_HAS,    16'd0,     16'd0, 8'd0);
		issue_command(FN_GET,    16'd0,     16'd0, 8'd0);
		issue_command(FN_REMOVE, 16'd0,     16'd0, 8'd0);
		issue_command(FN_ADD,    16'd0,     16'd0, 8'd0);
		issue_command(FN_ADD,    16'hFFFF,  16'd0, 8'd0);
		issue_command(FN_ADD,    16'd0,     16'd0, 8'd0);
		issue_command(FN_HAS,    16'd0,     16'd0, 8'd0);
		issue_command(FN_HAS,    16'hFFFF,  16'd0, 8'd0);
		issue_command(FN_HAS,    16'd1,     16'd0, 8'd0);
		issue_command(FN_GET,    16'd0,     16'd0, 8'd0);
		issue_command(FN_GET,    16'd0,     16'd0, 8'd1);
		issue_command(FN_GET,    16'd0,     16'd0, 8'd2);
		issue_command(FN_GET,    16'd0,     16'd0, 8'hFF);
		issue_command(FN_REMOVE, 16'd0,     16'd1, 8'd0);
		issue_command(FN_REMOVE, 16'd0,     16'd1, 8'd0);
		issue_command(FN_GET,    16'd0,     16'd0, 8'd0);
		issue_command(FN_ADD,    16'h5A5A,  16'd0, 8'd0);
		issue_command(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
		issue_command(3'd6, 16'h1234, 16'h0002, 8'd0);
		issue_command(3'd7, 16'h0000, 16'h0003, 8'd1);
		issue_command(FN_CLEAR,  16'd0,     16'd0, 8'd0);
		issue_command(FN_GET,    16'd0,     16'd0, 8'd0);

		src_gap_pct  = 19;
		sink_gap_pct = 72;
		random_phase(500);
		src_gap_pct  = 72;
		sink_gap_pct = 19;
		random_phase(500);
		src_gap_pct  = 0;
		sink_gap_pct = 0;
		random_phase(500);

		issue_command(FN_GET, 16'd0, 16'd0, 8'd0);

		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d commands: edge cases, then random mixes under three stall patterns;",
		         sent);
		$display("%0d results compared", checked);
		if (errors == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#(12 * 1000000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
